/* hdl/gdc_pkg.sv */
// Package for the gain-delay comb filter: sample and gain formats, delay store
// geometry, configuration register indexes and the output saturation function.
// No dependencies.
package gdc_pkg;

    localparam int MAX_DELAY   = 4096;
    localparam int SAMPLE_BITS = 24;
    localparam int GAIN_BITS   = 16;
    localparam int GAIN_FRAC   = 12;
    localparam int LEN_BITS    = $clog2(MAX_DELAY) + 1;
    localparam int ADDR_BITS   = $clog2(MAX_DELAY);
    localparam int PROD_BITS   = SAMPLE_BITS + GAIN_BITS;
    localparam int SHIFT_BITS  = PROD_BITS - GAIN_FRAC;
    localparam int CFG_BITS    = GAIN_BITS;
    localparam int CFG_IDX_BITS = 2;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic signed [GAIN_BITS-1:0]   t_gain;
    typedef logic [ADDR_BITS-1:0]          t_addr;
    typedef logic [LEN_BITS-1:0]           t_len;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_DELAY_LENGTH = 2'd0,
        CFG_GAIN         = 2'd1,
        CFG_ENABLE       = 2'd2
    } t_cfg_idx;

    // Clamp a scaled product to the Q1.23 range.
    function automatic t_sample sat_sample(input logic signed [SHIFT_BITS-1:0] v);
        logic [SHIFT_BITS-SAMPLE_BITS:0] top;
        t_sample                         res;
        top = v[SHIFT_BITS-1:SAMPLE_BITS-1];
        if ((&top) || !(|top)) begin
            res = v[SAMPLE_BITS-1:0];
        end else if (v[SHIFT_BITS-1]) begin
            res = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end else begin
            res = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
        return res;
    endfunction

endpackage

/* hdl/gain_delay_comb_filter.sv */
// Gain-delay comb filter: delay store in a synchronous RAM, gain multiply and
// saturation in a three-stage pipeline. Depends on gdc_pkg.
//
// Channel   Direction  Handshake                Payload
// input     in         i_valid / o_stall        i_sample_in
// output    out        o_valid / i_stall        o_sample_out
// config    in         i_cfg_we (no wait)       i_cfg_index, i_cfg_data
//
// One transaction is accepted per cycle while o_stall is low; the result passes
// through the s1, s2 and output registers. The rate is set by the single
// read-and-write access of the delay RAM per sample, which reads the old entry
// and writes the new one at one edge.
// Reset is synchronous; no clearing pass: a fill count marks which entries
// hold written samples, and unwritten entries read as zero. A stalled output
// fills the pipeline stages before o_stall is raised.
module gain_delay_comb_filter
    import gdc_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_in,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic signed [SAMPLE_BITS-1:0] o_sample_out,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [CFG_BITS-1:0]     i_cfg_data
);

    localparam t_len MAX_LEN = t_len'(MAX_DELAY);

    // Configuration
    t_len    r_delay_len;
    t_gain   r_gain;
    logic    r_enable;

    // Ring position and fill count
    t_addr   r_widx;
    t_len    r_fill;
    t_addr   n_widx;
    t_len    n_fill;

    logic [SAMPLE_BITS-1:0] mem [0:MAX_DELAY-1];

    // Pipeline stages
    logic    r_s1_valid;
    t_sample r_s1_rdata;
    logic    r_s1_hit;
    t_sample r_s1_sample;
    logic    r_s2_valid;
    logic signed [PROD_BITS-1:0] r_s2_prod;
    t_sample r_s2_sample;
    logic    r_o_valid;
    t_sample r_o_sample;

    logic    w_accept;
    logic    w_out_free;
    logic    w_s2_free;
    logic    w_s1_free;
    t_len    w_len;
    t_addr   w_idx;
    t_len    w_idx_inc;
    t_sample w_tap;
    logic signed [PROD_BITS-1:0]  w_prod;
    logic signed [PROD_BITS-1:0]  w_scaled;
    t_sample w_result;

    // Each stage moves when the one after it is empty or moving itself.
    assign w_out_free = !r_o_valid || !i_stall;
    assign w_s2_free  = !r_s2_valid || w_out_free;
    assign w_s1_free  = !r_s1_valid || w_s2_free;
    assign o_stall    = !w_s1_free;
    assign w_accept   = i_valid && w_s1_free;

    assign o_valid      = r_o_valid;
    assign o_sample_out = r_o_sample;

    always_comb begin
        if (r_delay_len == '0) begin
            w_len = t_len'(1);
        end else if (r_delay_len > MAX_LEN) begin
            w_len = MAX_LEN;
        end else begin
            w_len = r_delay_len;
        end
        // A shortened delay may leave the index past the new wrap point.
        if ({1'b0, r_widx} >= w_len) begin
            w_idx = '0;
        end else begin
            w_idx = r_widx;
        end
        w_idx_inc = {1'b0, w_idx} + t_len'(1);
        n_widx = r_widx;
        n_fill = r_fill;
        if (w_accept) begin
            n_widx = (w_idx_inc >= w_len) ? '0 : w_idx_inc[ADDR_BITS-1:0];
            // Entries are written in ascending order from zero, so the
            // written ones always form a prefix of the store.
            if ({1'b0, w_idx} == r_fill) begin
                n_fill = w_idx_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay_len <= t_len'(1);
            r_gain      <= t_gain'(1 << GAIN_FRAC);
            r_enable    <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DELAY_LENGTH: r_delay_len <= i_cfg_data[LEN_BITS-1:0];
                CFG_GAIN:         r_gain      <= i_cfg_data[GAIN_BITS-1:0];
                CFG_ENABLE:       r_enable    <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_widx     <= '0;
            r_fill     <= '0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_widx <= n_widx;
            r_fill <= n_fill;
            if (w_s1_free) begin
                r_s1_valid <= i_valid;
            end
            if (w_s2_free) begin
                r_s2_valid <= r_s1_valid;
            end
            if (w_out_free) begin
                r_o_valid <= r_s2_valid;
            end
        end
    end

    // Read-first RAM: the old sample comes out as the new one goes in.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_rdata  <= mem[w_idx];
            mem[w_idx]  <= i_sample_in;
            r_s1_hit    <= ({1'b0, w_idx} < r_fill);
            r_s1_sample <= i_sample_in;
        end
    end

    assign w_tap  = r_s1_hit ? r_s1_rdata : '0;
    assign w_prod = w_tap * r_gain;

    always_ff @(posedge i_clk) begin
        if (w_s2_free && r_s1_valid) begin
            r_s2_prod   <= w_prod;
            r_s2_sample <= r_s1_sample;
        end
    end

    assign w_scaled = r_s2_prod >>> GAIN_FRAC;
    assign w_result = r_enable ? sat_sample(w_scaled[SHIFT_BITS-1:0]) : r_s2_sample;

    always_ff @(posedge i_clk) begin
        if (w_out_free && r_s2_valid) begin
            r_o_sample <= w_result;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_stall_when_out_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_o_valid |-> !o_stall)
        else $error("input stalled while the output stage is empty");

    a_index_within_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_widx} <= r_fill) && (r_fill <= MAX_LEN))
        else $error("write index ahead of the fill count");

    a_fill_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_fill >= $past(r_fill)))
        else $error("fill count decreased");

    a_s1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !w_s2_free) |=> (r_s1_valid && $stable(r_s1_rdata)))
        else $error("RAM read data lost while the pipeline was blocked");
`endif

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for gain_delay_comb_filter: directed table, then random phases.
// Depends on gdc_pkg and the filter RTL; an internal model predicts each output sample not typed in the table.
module testbench;
    import gdc_pkg::*;

    localparam t_sample S_MAX = 24'sh7FFFFF;
    localparam t_sample S_MIN = 24'sh800000;
    localparam logic [CFG_IDX_BITS-1:0] CFG_NONE = 2'd3;
    localparam int HOLD_LEN = 300;
    localparam int N_PHASES = 9;
    localparam int PHASE_ITEMS = 45;
    localparam int PRESSURE_ITEMS = 100;

    typedef enum logic [1:0] {
        ROW_WRITE,
        ROW_SAMPLE,
        ROW_KNOWN
    } t_row_kind;

    typedef struct packed {
        t_row_kind              kind;
        logic [CFG_IDX_BITS-1:0] cfg_idx;
        logic [CFG_BITS-1:0]    cfg_data;
        t_sample                sample;
        t_sample                known_out;
    } t_row;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_valid = 1'b0;
    logic                    o_stall;
    t_sample                 i_sample_in = '0;
    logic                    o_valid;
    logic                    i_stall = 1'b0;
    t_sample                 o_sample_out;
    logic                    i_cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0] i_cfg_index = '0;
    logic [CFG_BITS-1:0]     i_cfg_data = '0;

    // Side-band of the input transaction: a typed expectation that replaces the prediction.
    logic    pin_on = 1'b0;
    t_sample pin_val = '0;

    // Mirror of the filter state and registers.
    t_sample     echo_line [0:MAX_DELAY-1];
    int unsigned echo_pos;
    t_len        cfg_len;
    t_gain       cfg_gain;
    logic        cfg_en;

    t_sample pending_out [$];
    t_row    directed [$];
    int      n_errors = 0;
    int      n_checked = 0;
    int      n_settings = 0;
    int      idle_pct = 0;
    int      stall_pct = 0;
    int      hold_req = 0;
    int      hold_ack = 0;
    int      hold_left = 0;

    gain_delay_comb_filter i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_sample_in (i_sample_in),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_sample_out(o_sample_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Feedforward comb: scaled sample from the delay line, or the input when bypassed.
    function automatic t_sample comb_response(input t_sample din);
        int unsigned span;
        int unsigned slot;
        longint      scaled;
        t_sample     dout;
        span = cfg_len;
        if (span == 0) span = 1;
        if (span > MAX_DELAY) span = MAX_DELAY;
        slot = echo_pos;
        if (slot >= span) slot = 0;
        if (cfg_en) begin
            scaled = (longint'(echo_line[slot]) * longint'(cfg_gain)) >>> GAIN_FRAC;
            if (scaled > longint'(S_MAX)) begin
                dout = S_MAX;
            end else if (scaled < longint'(S_MIN)) begin
                dout = S_MIN;
            end else begin
                dout = t_sample'(scaled);
            end
        end else begin
            dout = din;
        end
        echo_line[slot] = din;
        slot++;
        if (slot >= span) slot = 0;
        echo_pos = slot;
        return dout;
    endfunction

    always @(posedge i_clk) begin : scoreboard
        t_sample want;
        if (!i_rst_n) begin
            foreach (echo_line[k]) echo_line[k] = '0;
            echo_pos = 0;
            cfg_len  = t_len'(1);
            cfg_gain = 16'sh1000;
            cfg_en   = 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_DELAY_LENGTH: cfg_len  = i_cfg_data[LEN_BITS-1:0];
                    CFG_GAIN:         cfg_gain = i_cfg_data;
                    CFG_ENABLE:       cfg_en   = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_valid && !o_stall) begin
                want = comb_response(i_sample_in);
                if (pin_on) want = pin_val;
                pending_out.push_back(want);
            end
            if (o_valid && !i_stall) begin
                if (pending_out.size() == 0) begin
                    $display("%0t ns: unexpected sample_out %0d with nothing pending",
                             $time, o_sample_out);
                    n_errors++;
                end else begin
                    want = pending_out.pop_front();
                    n_checked++;
                    if (o_sample_out !== want) begin
                        $display("%0t ns: sample_out mismatch: expected %0d, actual %0d",
                                 $time, want, o_sample_out);
                        n_errors++;
                    end
                end
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off on request from the stimulus.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_req != hold_ack) begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_LEN;
            i_stall   <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    function automatic void add_write(input logic [CFG_IDX_BITS-1:0] idx,
                                      input logic [CFG_BITS-1:0] val);
        directed.push_back(t_row'{ROW_WRITE, idx, val, '0, '0});
    endfunction

    function automatic void add_sample(input t_sample s);
        directed.push_back(t_row'{ROW_SAMPLE, CFG_NONE, '0, s, '0});
    endfunction

    function automatic void add_known(input t_sample s, input t_sample k);
        directed.push_back(t_row'{ROW_KNOWN, CFG_NONE, '0, s, k});
    endfunction

    function automatic t_sample random_sample();
        case ($urandom_range(7))
            0:       return S_MAX;
            1:       return S_MIN;
            2:       return t_sample'(int'($urandom_range(64)) - 32);
            default: return t_sample'($urandom);
        endcase
    endfunction

    task automatic offer(input t_sample s, input logic pin, input t_sample pinned);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_sample_in <= s;
        pin_on      <= pin;
        pin_val     <= pinned;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // Registers change only once every outstanding sample has come out. The first
    // edge lets the scoreboard record a transaction accepted at the current edge.
    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_out.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_BITS-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic program_phase(input int phase);
        logic [CFG_BITS-1:0] len_val;
        logic [CFG_BITS-1:0] gain_val;
        logic                en_val;
        case ($urandom_range(9))
            0:       len_val = '0;
            1:       len_val = 16'd4096;
            2:       len_val = CFG_BITS'($urandom_range(8191, 4097));
            3:       len_val = CFG_BITS'($urandom);
            default: len_val = CFG_BITS'($urandom_range(12, 1));
        endcase
        case ($urandom_range(6))
            0:       gain_val = 16'h7FFF;
            1:       gain_val = 16'h8000;
            2:       gain_val = 16'h0000;
            3:       gain_val = 16'h1000;
            default: gain_val = CFG_BITS'($urandom);
        endcase
        en_val = ($urandom_range(3) != 0);
        // The first phases pin the register extremes.
        if (phase == 0) begin
            len_val  = 16'd4096;
            gain_val = 16'h8000;
            en_val   = 1'b1;
        end else if (phase == 1) begin
            len_val  = 16'd1;
            gain_val = 16'h7FFF;
            en_val   = 1'b1;
        end else if (phase == 2) begin
            en_val = 1'b0;
        end
        write_reg(CFG_DELAY_LENGTH, len_val);
        write_reg(CFG_GAIN, gain_val);
        write_reg(CFG_ENABLE, (CFG_BITS'($urandom) & 16'hFFFE) | CFG_BITS'(en_val));
        if ($urandom_range(2) == 0) write_reg(CFG_NONE, CFG_BITS'($urandom));
        n_settings++;
    endtask

    initial begin
        add_known(24'sh000000, 24'sh000000);
        add_known(S_MAX, S_MAX);
        add_known(S_MIN, S_MIN);
        add_known(24'shFFFFFF, 24'shFFFFFF);
        add_known(24'sh555555, 24'sh555555);
        add_known(24'shAAAAAA, 24'shAAAAAA);
        add_write(CFG_ENABLE, 16'h0001);
        add_known(24'sd100, 24'shAAAAAA);
        add_known(S_MAX, 24'sd100);
        add_write(CFG_GAIN, 16'h7FFF);
        add_known(S_MIN, S_MAX);
        add_write(CFG_GAIN, 16'h8000);
        add_known(24'sd5, S_MAX);
        add_sample(24'sd0);
        add_write(CFG_GAIN, 16'h0000);
        add_known(24'sd1234, 24'sd0);
        add_write(CFG_GAIN, 16'hFFFF);
        add_sample(24'sd7);
        add_write(CFG_GAIN, 16'h7FFF);
        add_sample(S_MIN);
        add_known(24'sd0, S_MIN);
        // A delay length of zero behaves as one.
        add_write(CFG_DELAY_LENGTH, 16'h0000);
        add_sample(24'sh123456);
        add_write(CFG_GAIN, 16'h1000);
        add_write(CFG_DELAY_LENGTH, 16'd3);
        add_sample(24'sh000011);
        add_sample(24'sh000022);
        add_sample(24'sh000033);
        add_sample(24'sh000044);
        add_sample(24'sh7FFF00);
        // Shortening the delay below the write position restarts the ring.
        add_write(CFG_DELAY_LENGTH, 16'd2);
        add_sample(24'sh000055);
        add_write(CFG_NONE, 16'h0000);
        add_sample(24'sh000066);
        // An oversized length is clamped to the full store.
        add_write(CFG_DELAY_LENGTH, 16'hFFFF);
        add_sample(24'sh000077);
        add_write(CFG_ENABLE, 16'h0000);
        add_known(24'sh00ABCD, 24'sh00ABCD);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[r]) begin
            case (directed[r].kind)
                ROW_WRITE: begin
                    settle();
                    write_reg(directed[r].cfg_idx, directed[r].cfg_data);
                end
                ROW_SAMPLE: offer(directed[r].sample, 1'b0, '0);
                default:    offer(directed[r].sample, 1'b1, directed[r].known_out);
            endcase
        end
        n_settings++;

        for (int phase = 0; phase < N_PHASES; phase++) begin
            settle();
            program_phase(phase);
            case (phase % 4)
                0: begin idle_pct = 0;  stall_pct <= 0;  end
                1: begin idle_pct = 81; stall_pct <= 0;  end
                2: begin idle_pct = 0;  stall_pct <= 81; end
                default: begin idle_pct = 37; stall_pct <= 37; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) offer(random_sample(), 1'b0, '0);

            // Back-pressure: the output holds off while samples keep arriving.
            if (phase == 4) begin
                settle();
                program_phase(phase);
                idle_pct = 0;
                stall_pct <= 0;
                hold_req <= hold_req + 1;
                for (int n = 0; n < PRESSURE_ITEMS; n++) offer(random_sample(), 1'b0, '0);
            end
        end

        settle();
        if (pending_out.size() != 0) n_errors++;
        $display("Checked %0d output samples over %0d register settings,", n_checked,
                 n_settings);
        $display("with bypass, gain and delay extremes, idle gaps and a long output hold.");
        if (n_errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("Run timed out with %0d output samples outstanding.", pending_out.size());
        $display("FAIL");
        $finish;
    end

endmodule

/* gain_delay_comb_filter.f */
hdl/gdc_pkg.sv
hdl/gain_delay_comb_filter.sv
tb/sv/testbench.sv
